/* rtl/core/ifd_pkg.sv */
// ifd_pkg: shared types and constants for the ir frame deframer
// no dependencies; imported by every module of the block
package ifd_pkg;

  localparam logic [7:0] HEAD_BYTE = 8'hAA;
  localparam logic [7:0] TAIL_BYTE = 8'hBB;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned UID_BITS  = 2 * BYTE_BITS;

  // parse position inside a six-byte frame
  typedef enum logic [2:0] {
    PH_HEAD = 3'd0,
    PH_DATA = 3'd1,
    PH_UIDL = 3'd2,
    PH_UIDH = 3'd3,
    PH_COPY = 3'd4,
    PH_TAIL = 3'd5
  } phase_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic                 frame_valid;
    logic [BYTE_BITS-1:0] frame_data;
    logic [UID_BITS-1:0]  frame_uid;
    logic [UID_BITS-1:0]  highest_uid;
  } out_item_t;

  // handshake between the input register and the parser
  typedef struct packed {
    logic                 valid;
    logic [BYTE_BITS-1:0] rx_byte;
  } stage_t;

endpackage

/* rtl/core/ifd_chan_if.sv */
// ifd_chan_if: valid/ready channel carrying one payload item per transfer
// payload type is set by the instantiating module
interface ifd_chan_if #(
  parameter type item_t = logic [7:0]
) ();
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/ifd_in_stage.sv */
// ifd_in_stage: input register for received bytes
// depends on ifd_pkg
module ifd_in_stage
  import ifd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [BYTE_BITS-1:0] in_byte,
  output logic                 in_ready,
  input  logic                 take,
  output stage_t               stage
);

  logic                 valid_r, valid_nxt;
  logic [BYTE_BITS-1:0] byte_r, byte_nxt;
  logic                 load;

  // reload whenever the held byte is gone or leaves this cycle
  assign in_ready = !valid_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    if (load) begin
      valid_nxt = 1'b1;
      byte_nxt  = in_byte;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    byte_r <= byte_nxt;
  end

  assign stage.valid   = valid_r;
  assign stage.rx_byte = byte_r;

endmodule

/* rtl/core/ifd_parser.sv */
// ifd_parser: frame parse state, held payload and uid, running uid maximum
// depends on ifd_pkg
module ifd_parser
  import ifd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  logic [BYTE_BITS-1:0] rx_byte,
  output out_item_t            result
);

  phase_t               phase_r, phase_nxt;
  logic [BYTE_BITS-1:0] payload_r, payload_nxt;
  logic [UID_BITS-1:0]  uid_r, uid_nxt;
  logic [UID_BITS-1:0]  max_r, max_nxt;
  phase_t               ph;
  logic                 done;

  always_comb begin
    ph          = (rx_byte == HEAD_BYTE) ? PH_HEAD : phase_r;
    phase_nxt   = PH_HEAD;
    payload_nxt = payload_r;
    uid_nxt     = uid_r;
    max_nxt     = max_r;
    done        = 1'b0;
    unique case (ph)
      PH_DATA: begin
        payload_nxt = rx_byte;
        phase_nxt   = PH_UIDL;
      end
      PH_UIDL: begin
        uid_nxt   = {{BYTE_BITS{1'b0}}, rx_byte};
        phase_nxt = PH_UIDH;
      end
      PH_UIDH: begin
        uid_nxt   = {rx_byte, uid_r[BYTE_BITS-1:0]};
        phase_nxt = PH_COPY;
      end
      PH_COPY: begin
        phase_nxt = (rx_byte == payload_r) ? PH_TAIL : PH_HEAD;
      end
      PH_TAIL: begin
        if (rx_byte == TAIL_BYTE) begin
          done = 1'b1;
          if (uid_r > max_r) begin
            max_nxt = uid_r;
          end
        end
        phase_nxt = PH_HEAD;
      end
      default: begin
        // waiting for header; unused codes behave the same
        phase_nxt = (rx_byte == HEAD_BYTE) ? PH_DATA : PH_HEAD;
      end
    endcase
  end

  always_comb begin
    result.frame_valid = done;
    result.frame_data  = done ? payload_r : '0;
    result.frame_uid   = done ? uid_r : '0;
    result.highest_uid = max_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEAD;
      payload_r <= '0;
      uid_r     <= '0;
      max_r     <= '0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      payload_r <= payload_nxt;
      uid_r     <= uid_nxt;
      max_r     <= max_nxt;
    end
  end

endmodule

/* rtl/core/ifd_out_stage.sv */
// ifd_out_stage: result register in front of the output channel
// depends on ifd_pkg
module ifd_out_stage
  import ifd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t result,
  output logic      can_load,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_ready
);

  logic      valid_r, valid_nxt;
  out_item_t item_r, item_nxt;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (load) begin
      valid_nxt = 1'b1;
      item_nxt  = result;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

/* rtl/core/ir_frame_deframer_core.sv */
// ir_frame_deframer_core: top level of the byte-stream frame deframer
// depends on ifd_pkg, ifd_chan_if, ifd_in_stage, ifd_parser, ifd_out_stage
//
// usage
//   in_ch  : one received byte per transfer (payload.rx_byte)
//   out_ch : exactly one result per input byte: frame_valid, frame_data,
//            frame_uid and highest_uid; data and uid read zero when the byte
//            did not complete a frame
// frames are 0xAA, data, uid low, uid high, data copy, 0xBB; any 0xAA byte
// restarts parsing at the data position
// result path: each byte moves from the input register through the parser
//   into the result register, which offers its result on out_ch
// throughput: one byte per cycle while out_ch takes results, set by the
//   parser update between the input register and the result register
// reset: synchronous, active low; parser returns to header search, held
//   data, uid and the uid maximum clear, both registers empty
// stall: a result waiting on out_ch holds in the result register; the
//   input register still takes a byte if it is empty, then in_ch.ready
//   drops until the receiver takes the result
module ir_frame_deframer_core
  import ifd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ifd_chan_if.sink   in_ch,
  ifd_chan_if.source out_ch
);

  stage_t    stage;
  out_item_t result;
  logic      can_load;
  logic      advance;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;

  // the parser commits a byte when it moves into the result register
  assign advance = stage.valid && can_load;

  ifd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.payload.rx_byte),
    .in_ready (in_ready),
    .take     (advance),
    .stage    (stage)
  );

  ifd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .rx_byte (stage.rx_byte),
    .result  (result)
  );

  ifd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .result    (result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_ready (out_ch.ready)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

`ifndef SYNTH
  // a completed frame never carries a uid above the running maximum
  a_uid_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.frame_valid |-> out_item.frame_uid <= out_item.highest_uid)
    else $error("frame uid above highest uid");

  // no completed frame means zeroed data and uid
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.frame_valid |-> out_item.frame_data == '0 && out_item.frame_uid == '0)
    else $error("nonzero fields without a completed frame");

  // a held byte that cannot advance stays held
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stage.valid && !can_load |=> stage.valid && $stable(stage.rx_byte))
    else $error("input register lost a byte during stall");

  // a stalled result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ch.ready |=> out_valid && $stable(out_item))
    else $error("result register changed during stall");
`endif

endmodule
